FILE: src/fpd_pkg.sv
// Package: shared types and codes for the flight phase detector.
`timescale 1ns / 1ps

package fpd_pkg;

    localparam int PHASE_W = 3;
    localparam int CNT_W   = 8;

    localparam logic [PHASE_W-1:0] PH_PAD     = 3'd0;
    localparam logic [PHASE_W-1:0] PH_ARMED   = 3'd1;
    localparam logic [PHASE_W-1:0] PH_POWERED = 3'd2;
    localparam logic [PHASE_W-1:0] PH_COAST   = 3'd3;
    localparam logic [PHASE_W-1:0] PH_DESCENT = 3'd4;
    localparam logic [PHASE_W-1:0] PH_CANOPY  = 3'd5;
    localparam logic [PHASE_W-1:0] PH_LANDED  = 3'd6;

    localparam logic [1:0] CMD_SAMPLE = 2'd0;
    localparam logic [1:0] CMD_ARM    = 2'd1;
    localparam logic [1:0] CMD_FIRE   = 2'd2;

    localparam logic [2:0] REG_LIFTOFF_ACCEL    = 3'd0;
    localparam logic [2:0] REG_BURNOUT_ACCEL    = 3'd1;
    localparam logic [2:0] REG_DEPLOY_ACCEL     = 3'd2;
    localparam logic [2:0] REG_LANDING_VELOCITY = 3'd3;
    localparam logic [2:0] REG_LIFTOFF_CONFIRM  = 3'd4;
    localparam logic [2:0] REG_PHASE_CONFIRM    = 3'd5;
    localparam logic [2:0] REG_LANDING_CONFIRM  = 3'd6;
    localparam logic [2:0] REG_PYRO_HOLD_MS     = 3'd7;

    typedef struct packed {
        logic [1:0]         cmd;
        logic [21:0]        abs_accel;
        logic signed [31:0] altitude;
        logic signed [31:0] vertical_vel;
        logic [31:0]        now_ms;
    } fpd_in_t;

    typedef struct packed {
        logic [PHASE_W-1:0] phase;
        logic               phase_changed;
        logic               pyro_on;
        logic [CNT_W-1:0]   confirm_count;
        logic signed [31:0] apogee_alt;
    } fpd_out_t;

    typedef struct packed {
        logic [21:0]        liftoff_accel;
        logic [21:0]        burnout_accel;
        logic [21:0]        deploy_accel;
        logic signed [31:0] landing_velocity;
        logic [CNT_W-1:0]   liftoff_confirm;
        logic [CNT_W-1:0]   phase_confirm;
        logic [CNT_W-1:0]   landing_confirm;
        logic [15:0]        pyro_hold_ms;
    } fpd_cfg_t;

endpackage

FILE: src/fpd_cfg.sv
// Configuration register file for the flight phase detector.
`timescale 1ns / 1ps

module fpd_cfg
    import fpd_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_addr,
    input  logic [31:0] cfg_wdata,
    output fpd_cfg_t    cfg
);

    fpd_cfg_t cfg_reg;
    fpd_cfg_t cfg_next;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_we) begin
            unique case (cfg_addr)
                REG_LIFTOFF_ACCEL:    cfg_next.liftoff_accel    = cfg_wdata[21:0];
                REG_BURNOUT_ACCEL:    cfg_next.burnout_accel    = cfg_wdata[21:0];
                REG_DEPLOY_ACCEL:     cfg_next.deploy_accel     = cfg_wdata[21:0];
                REG_LANDING_VELOCITY: cfg_next.landing_velocity = cfg_wdata;
                REG_LIFTOFF_CONFIRM:  cfg_next.liftoff_confirm  = cfg_wdata[7:0];
                REG_PHASE_CONFIRM:    cfg_next.phase_confirm    = cfg_wdata[7:0];
                REG_LANDING_CONFIRM:  cfg_next.landing_confirm  = cfg_wdata[7:0];
                REG_PYRO_HOLD_MS:     cfg_next.pyro_hold_ms     = cfg_wdata[15:0];
                default:              cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.liftoff_accel    <= 22'd110000;
            cfg_reg.burnout_accel    <= 22'd60000;
            cfg_reg.deploy_accel     <= 22'd70000;
            cfg_reg.landing_velocity <= 32'sd2000;
            cfg_reg.liftoff_confirm  <= 8'd3;
            cfg_reg.phase_confirm    <= 8'd5;
            cfg_reg.landing_confirm  <= 8'd10;
            cfg_reg.pyro_hold_ms     <= 16'd4000;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

FILE: src/fpd_core.sv
// Phase state, confirm counter, apogee and pyro logic for one word.
`timescale 1ns / 1ps

module fpd_core
    import fpd_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     advance,
    input  fpd_in_t  in_word,
    input  fpd_cfg_t cfg,
    output fpd_out_t result
);

    logic [PHASE_W-1:0] phase_reg, phase_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic signed [31:0] apogee_reg, apogee_next;
    logic               pyro_reg, pyro_next;
    logic [31:0]        fire_time_reg, fire_time_next;

    logic               hit;
    logic [CNT_W-1:0]   confirm;
    logic [PHASE_W-1:0] target;
    logic               counting;
    logic [CNT_W-1:0]   count_inc;
    logic signed [35:0] alt_x10, apo_x9;
    logic [31:0]        elapsed;
    logic               pyro_cmd;

    // apogee raised before the coast test sees it
    always_comb begin
        apogee_next = apogee_reg;
        if (in_word.cmd == CMD_SAMPLE && in_word.altitude > apogee_reg) begin
            apogee_next = in_word.altitude;
        end
    end

    assign alt_x10 = 36'(in_word.altitude) * 36'sd10;
    assign apo_x9  = 36'(apogee_next) * 36'sd9;

    always_comb begin
        hit      = 1'b0;
        confirm  = cfg.phase_confirm;
        target   = phase_reg;
        counting = 1'b1;
        unique case (phase_reg)
            PH_ARMED: begin
                hit     = in_word.abs_accel > cfg.liftoff_accel;
                confirm = cfg.liftoff_confirm;
                target  = PH_POWERED;
            end
            PH_POWERED: begin
                hit    = in_word.abs_accel < cfg.burnout_accel;
                target = PH_COAST;
            end
            PH_COAST: begin
                hit    = alt_x10 < apo_x9;
                target = PH_DESCENT;
            end
            PH_DESCENT: begin
                hit    = in_word.abs_accel > cfg.deploy_accel;
                target = PH_CANOPY;
            end
            PH_CANOPY: begin
                hit     = in_word.vertical_vel < cfg.landing_velocity;
                confirm = cfg.landing_confirm;
                target  = PH_LANDED;
            end
            default: counting = 1'b0;
        endcase
    end

    // saturating count
    assign count_inc = (count_reg == {CNT_W{1'b1}}) ? count_reg : count_reg + 1'b1;

    always_comb begin
        phase_next     = phase_reg;
        count_next     = count_reg;
        pyro_cmd       = pyro_reg;
        fire_time_next = fire_time_reg;
        priority case (in_word.cmd)
            CMD_SAMPLE: begin
                if (counting) begin
                    count_next = hit ? count_inc : '0;
                    if (count_next > confirm) begin
                        phase_next = target;
                        count_next = '0;
                        if (phase_reg == PH_COAST) begin
                            pyro_cmd       = 1'b1;
                            fire_time_next = in_word.now_ms;
                        end
                    end
                end
            end
            CMD_ARM: phase_next = PH_ARMED;
            CMD_FIRE: begin
                pyro_cmd       = 1'b1;
                fire_time_next = in_word.now_ms;
            end
            default: ;
        endcase
    end

    assign elapsed   = in_word.now_ms - fire_time_next;
    assign pyro_next = pyro_cmd && !(elapsed > 32'(cfg.pyro_hold_ms));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg     <= PH_PAD;
            count_reg     <= '0;
            apogee_reg    <= '0;
            pyro_reg      <= 1'b0;
            fire_time_reg <= '0;
        end else if (advance) begin
            phase_reg     <= phase_next;
            count_reg     <= count_next;
            apogee_reg    <= apogee_next;
            pyro_reg      <= pyro_next;
            fire_time_reg <= fire_time_next;
        end
    end

    always_comb begin
        result.phase         = phase_next;
        result.phase_changed = phase_next != phase_reg;
        result.pyro_on       = pyro_next;
        result.confirm_count = count_next;
        result.apogee_alt    = apogee_next;
    end

endmodule

FILE: src/flight_phase_detector.sv
// Top level of the flight phase detector: word registers around the phase logic.
//
// Usage: the s_ channel takes one word per sample or command (cmd, abs_accel,
// altitude, vertical_vel, now_ms) under valid/ready. Each accepted word gives
// exactly one result word on the m_ channel: phase after the word, a phase
// change flag, pyro drive level, confirm count and tracked apogee.
// The word lands in the input register, then the phase logic runs combinationally
// into the result register, which drives m_valid and m_data.
// Throughput is one word per cycle while the receiver keeps up; the state registers
// update as a word moves from the input register to the result register.
// When the receiver stalls the result register holds and the input register
// keeps one more word; s_ready drops only when both are full and m_ready is low.
// Threshold registers are written through cfg_we/cfg_addr/cfg_wdata and take
// effect on the next word; write them only while the block is idle.
// Reset (aresetn low, synchronous) empties both registers, sets phase to pad,
// clears counter, apogee and pyro, and loads the default thresholds.
`timescale 1ns / 1ps

module flight_phase_detector
    import fpd_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  fpd_in_t     s_data,
    output logic        m_valid,
    input  logic        m_ready,
    output fpd_out_t    m_data,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_addr,
    input  logic [31:0] cfg_wdata
);

    fpd_cfg_t cfg;
    fpd_out_t result;

    logic     in_valid_reg;
    fpd_in_t  in_data_reg;
    logic     out_valid_reg;
    fpd_out_t out_data_reg;
    logic     advance;

    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    fpd_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    fpd_core u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .advance (advance),
        .in_word (in_data_reg),
        .cfg     (cfg),
        .result  (result)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s_ready) begin
                in_valid_reg <= s_valid;
            end
            if (advance) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            in_data_reg <= s_data;
        end
        if (advance) begin
            out_data_reg <= result;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_data_reg;

endmodule
